/* hdl/cts_pkg.sv */
// Types, token codes and character tables for the C token scanner.
// Used by every module of the scanner; depends on nothing.
`default_nettype none
package cts_pkg;

  localparam int unsigned KW_BYTES   = 8;
  localparam int unsigned KW_COUNT   = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] CODE_NONE  = 7'd0;
  localparam logic [6:0] CODE_DEC   = 7'd82;
  localparam logic [6:0] CODE_OCT   = 7'd83;
  localparam logic [6:0] CODE_HEX   = 7'd84;
  localparam logic [6:0] CODE_IDENT = 7'd85;
  localparam logic [6:0] CODE_SHL   = 7'd69;
  localparam logic [6:0] CODE_SHLEQ = 7'd70;
  localparam logic [6:0] CODE_SHR   = 7'd76;
  localparam logic [6:0] CODE_SHREQ = 7'd77;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDEF = 2'd1;
  localparam logic [1:0] ERR_DOTS  = 2'd2;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_OCT, M_HEX, M_DEC, M_OP, M_SHIFT, M_ESC
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  token_code;
    logic [1:0]  error_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    out_item_t                 tok;
    logic                      is_word;
    logic [8*KW_BYTES-1:0]     word;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       s0;
    rec_t       s1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [6:0] single_code(input logic [7:0] b);
    unique case (b)
      "-": return 7'd33;  "!": return 7'd37;  "%": return 7'd39;
      "&": return 7'd41;  "(": return 7'd44;  ")": return 7'd45;
      "*": return 7'd46;  ",": return 7'd48;  "/": return 7'd50;
      ":": return 7'd52;  ";": return 7'd53;  "?": return 7'd54;
      "[": return 7'd55;  "]": return 7'd56;  "^": return 7'd57;
      "{": return 7'd59;  "|": return 7'd60;  "}": return 7'd63;
      "~": return 7'd64;  "+": return 7'd65;  "<": return 7'd68;
      "=": return 7'd72;  ">": return 7'd74;  8'h22: return 7'd78;
      8'h27: return 7'd79; "#": return 7'd80;
      default: return CODE_NONE;
    endcase
  endfunction

  function automatic logic can_extend(input logic [7:0] b);
    return b == "-" || b == "!" || b == "%" || b == "*" || b == "^" ||
           b == "=" || b == "/" || b == "&" || b == "|" || b == "+" ||
           b == "<" || b == ">";
  endfunction

  function automatic logic [6:0] pair_code(input logic [7:0] f, input logic [7:0] s);
    logic [6:0] c;
    c = CODE_NONE;
    if (s == "=") begin
      unique case (f)
        "-": c = 7'd35;  "!": c = 7'd38;  "%": c = 7'd40;
        "&": c = 7'd43;  "*": c = 7'd47;  "/": c = 7'd51;
        "^": c = 7'd58;  "|": c = 7'd62;  "+": c = 7'd67;
        "<": c = 7'd71;  "=": c = 7'd73;  ">": c = 7'd75;
        default: c = CODE_NONE;
      endcase
    end else if (f == "-" && s == "-") c = 7'd34;
    else if (f == "-" && s == ">") c = 7'd36;
    else if (f == "&" && s == "&") c = 7'd42;
    else if (f == "|" && s == "|") c = 7'd61;
    else if (f == "+" && s == "+") c = 7'd66;
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    unique case (k)
      0, 2, 3, 9, 10, 14, 17, 29: return 4'd4;
      13, 16: return 4'd3;
      7, 15: return 4'd2;
      1, 4, 12, 20, 27, 31: return 4'd5;
      8, 11, 19, 21, 22, 23, 24, 25: return 4'd6;
      6, 26: return 4'd7;
      default: return 4'd8;
    endcase
  endfunction

  function automatic logic [63:0] kw_raw(input int unsigned k);
    unique case (k)
      0:  return 64'("auto");     1:  return 64'("break");
      2:  return 64'("case");     3:  return 64'("char");
      4:  return 64'("const");    5:  return 64'("continue");
      6:  return 64'("default");  7:  return 64'("do");
      8:  return 64'("double");   9:  return 64'("else");
      10: return 64'("enum");     11: return 64'("extern");
      12: return 64'("float");    13: return 64'("for");
      14: return 64'("goto");     15: return 64'("if");
      16: return 64'("int");      17: return 64'("long");
      18: return 64'("register"); 19: return 64'("return");
      20: return 64'("short");    21: return 64'("signed");
      22: return 64'("sizeof");   23: return 64'("static");
      24: return 64'("struct");   25: return 64'("switch");
      26: return 64'("typedef");  27: return 64'("union");
      28: return 64'("unsigned"); 29: return 64'("void");
      30: return 64'("volatile"); default: return 64'("while");
    endcase
  endfunction

  // word buffer holds byte 0 in the top byte
  function automatic logic [63:0] kw_aligned(input int unsigned k);
    return kw_raw(k) << (8 * (KW_BYTES - kw_len(k)));
  endfunction

  function automatic logic [63:0] kw_mask(input int unsigned k);
    return ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * kw_len(k)));
  endfunction

  function automatic rec_t flush_rec(input mode_t m, input logic [7:0] pend,
                                     input logic [1:0] dots, input logic [31:0] start,
                                     input logic [15:0] len, input logic [63:0] word,
                                     input logic [15:0] line);
    rec_t r;
    r = '0;
    r.tok.token_start  = start;
    r.tok.token_length = len;
    r.tok.line_number  = line;
    r.word             = word;
    r.tok.error_kind   = ERR_NONE;
    unique case (m)
      M_IDENT: begin
        r.is_word        = 1'b1;
        r.tok.token_code = CODE_IDENT;
      end
      M_OCT:   r.tok.token_code = CODE_OCT;
      M_HEX:   r.tok.token_code = CODE_HEX;
      M_DEC:   r.tok.token_code = CODE_DEC;
      M_OP:    r.tok.token_code = single_code(pend);
      M_SHIFT: r.tok.token_code = (pend == "<") ? CODE_SHL : CODE_SHR;
      default: r.tok.token_code = CODE_NONE;
    endcase
    if ((m == M_OCT || m == M_HEX || m == M_DEC) && dots == 2'd2) begin
      r.tok.token_code = CODE_NONE;
      r.tok.error_kind = ERR_DOTS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/cts_front.sv */
// Front end: scans one byte per transfer and pushes finished token records.
// Depends on cts_pkg.
`default_nettype none
module cts_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cts_pkg::in_item_t in_data,
  input  wire logic            q_room,
  output cts_pkg::push_t       push
);

  cts_pkg::mode_t mode_r, mode_nxt;
  logic [63:0] word_r, word_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [1:0]  dots_r, dots_nxt;
  logic [31:0] start_r, start_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] line_r, line_nxt;
  logic [31:0] off_r;

  logic [7:0] b;
  logic       take, brk, do_begin, imm_v, fin_v;
  cts_pkg::rec_t rec_a, rec_b, rec_c;
  logic [6:0] pc, sc;

  assign in_ready = q_room;
  assign take     = in_valid && q_room;
  assign b        = in_data.text_byte;

  always_comb begin
    mode_nxt  = mode_r;
    word_nxt  = word_r;
    pend_nxt  = pend_r;
    dots_nxt  = dots_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    brk       = 1'b0;
    imm_v     = 1'b0;
    rec_b     = '0;
    rec_b.tok.line_number = line_r;
    pc = cts_pkg::pair_code(pend_r, b);
    sc = cts_pkg::single_code(b);
    unique case (mode_r)
      cts_pkg::M_IDENT: begin
        if (cts_pkg::is_alpha(b) || cts_pkg::is_digit(b)) begin
          if (len_r < 16'(cts_pkg::KW_BYTES)) word_nxt[63 - 8*len_r[2:0] -: 8] = b;
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
        end else brk = 1'b1;
      end
      cts_pkg::M_OCT, cts_pkg::M_HEX, cts_pkg::M_DEC: begin
        if (mode_r == cts_pkg::M_OCT && len_r == 16'd1 && dots_r == 2'd0 &&
            (b == "x" || b == "X")) begin
          mode_nxt = cts_pkg::M_HEX;
          len_nxt  = 16'd2;
        end else if ((mode_r == cts_pkg::M_OCT && ((b >= "0" && b <= "7") || b == ".")) ||
                     (mode_r == cts_pkg::M_HEX && (cts_pkg::is_digit(b) ||
                       (b >= "A" && b <= "F") || b == ".")) ||
                     (mode_r == cts_pkg::M_DEC && (cts_pkg::is_digit(b) || b == "."))) begin
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
          if (b == "." && dots_r != 2'd2) dots_nxt = dots_r + 2'd1;
        end else brk = 1'b1;
      end
      cts_pkg::M_OP: begin
        if ((pend_r == "<" || pend_r == ">") && b == pend_r) begin
          mode_nxt = cts_pkg::M_SHIFT;
          len_nxt  = 16'd2;
        end else if (pc != cts_pkg::CODE_NONE) begin
          imm_v = 1'b1;
          rec_b.tok.token_code   = pc;
          rec_b.tok.token_start  = start_r;
          rec_b.tok.token_length = 16'd2;
          mode_nxt = cts_pkg::M_IDLE;
        end else brk = 1'b1;
      end
      cts_pkg::M_SHIFT: begin
        if (b == "=") begin
          imm_v = 1'b1;
          rec_b.tok.token_code   = (pend_r == "<") ? cts_pkg::CODE_SHLEQ : cts_pkg::CODE_SHREQ;
          rec_b.tok.token_start  = start_r;
          rec_b.tok.token_length = 16'd3;
          mode_nxt = cts_pkg::M_IDLE;
        end else brk = 1'b1;
      end
      cts_pkg::M_ESC: begin
        imm_v = 1'b1;
        rec_b.tok.token_code   = cts_pkg::CODE_NONE;
        rec_b.tok.token_start  = start_r;
        rec_b.tok.token_length = 16'd2;
        mode_nxt = cts_pkg::M_IDLE;
      end
      default: ;
    endcase

    do_begin = brk || mode_r == cts_pkg::M_IDLE;
    if (do_begin) begin
      mode_nxt  = cts_pkg::M_IDLE;
      if (cts_pkg::is_alpha(b) || cts_pkg::is_digit(b) || b == "." || b == 8'h5C ||
          cts_pkg::can_extend(b)) begin
        start_nxt = off_r;
        len_nxt   = 16'd1;
        dots_nxt  = 2'd0;
      end
      if (cts_pkg::is_alpha(b)) begin
        mode_nxt = cts_pkg::M_IDENT;
        word_nxt[63 -: 8] = b;
      end else if (b == "0") begin
        mode_nxt = cts_pkg::M_OCT;
      end else if (cts_pkg::is_digit(b) || b == ".") begin
        mode_nxt = cts_pkg::M_DEC;
        if (b == ".") dots_nxt = 2'd1;
      end else if (b == " " || b == 8'h09 || b == 8'h0D) begin
      end else if (b == 8'h0A) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
      end else if (b == 8'h5C) begin
        mode_nxt = cts_pkg::M_ESC;
      end else if (cts_pkg::can_extend(b)) begin
        mode_nxt = cts_pkg::M_OP;
        pend_nxt = b;
      end else begin
        imm_v = 1'b1;
        rec_b.tok.token_code   = sc;
        rec_b.tok.error_kind   = (sc != cts_pkg::CODE_NONE) ? cts_pkg::ERR_NONE
                                                            : cts_pkg::ERR_UNDEF;
        rec_b.tok.token_start  = off_r;
        rec_b.tok.token_length = 16'd1;
      end
    end

    fin_v = in_data.end_of_text && mode_nxt != cts_pkg::M_IDLE;
    rec_a = cts_pkg::flush_rec(mode_r, pend_r, dots_r, start_r, len_r, word_r, line_r);
    rec_c = cts_pkg::flush_rec(mode_nxt, pend_nxt, dots_nxt, start_nxt, len_nxt,
                               word_nxt, line_r);

    push = '0;
    if (take) begin
      push.n  = 2'(brk) + 2'(imm_v) + 2'(fin_v);
      push.s0 = brk ? rec_a : (imm_v ? rec_b : rec_c);
      push.s1 = imm_v ? rec_b : rec_c;
      if (push.n == 2'd1) push.s0.tok.last_of_run = 1'b1;
      else push.s1.tok.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cts_pkg::M_IDLE;
      line_r <= 16'd1;
      off_r  <= '0;
    end else if (take) begin
      mode_r <= fin_v ? cts_pkg::M_IDLE : mode_nxt;
      line_r <= line_nxt;
      off_r  <= off_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      pend_r  <= '0;
      dots_r  <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (take) begin
      word_r  <= word_nxt;
      pend_r  <= pend_nxt;
      dots_r  <= dots_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/cts_queue.sv */
// Token record queue: up to two pushes and one pop per cycle.
// Depends on cts_pkg.
`default_nettype none
module cts_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cts_pkg::push_t push,
  output logic               room,
  input  wire logic          pop,
  output logic               not_empty,
  output cts_pkg::rec_t      head
);

  localparam int unsigned AW = $clog2(cts_pkg::QUEUE_DEPTH);

  cts_pkg::rec_t  q_r [cts_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_pop;

  assign room      = cnt_r <= (AW+1)'(cts_pkg::QUEUE_DEPTH - 2);
  assign not_empty = cnt_r != '0;
  assign head      = q_r[rp_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push.n);
      rp_r  <= rp_r + AW'(do_pop);
      cnt_r <= cnt_r + (AW+1)'(push.n) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wp_r] <= push.s0;
    if (push.n == 2'd2) q_r[wp_r + AW'(1)] <= push.s1;
  end

endmodule
`default_nettype wire

/* hdl/cts_back.sv */
// Back end: resolves keywords on the queue head and holds the output register.
// Depends on cts_pkg.
`default_nettype none
module cts_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              not_empty,
  input  wire cts_pkg::rec_t     head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cts_pkg::out_item_t     out_data
);

  logic                 out_valid_r;
  cts_pkg::out_item_t   out_r, tok;

  assign pop       = not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    tok = head.tok;
    if (head.is_word) begin
      tok.token_code = cts_pkg::CODE_IDENT;
      for (int k = cts_pkg::KW_COUNT - 1; k >= 0; k--) begin
        if (head.tok.token_length == 16'(cts_pkg::kw_len(k)) &&
            ((head.word ^ cts_pkg::kw_aligned(k)) & cts_pkg::kw_mask(k)) == '0)
          tok.token_code = 7'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (pop) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= tok;
  end

endmodule
`default_nettype wire

/* hdl/c_token_scanner.sv */
// Top level of the C token scanner: front scanner, record queue, back end.
// Depends on cts_pkg, cts_front, cts_queue, cts_back.
// Takes one byte of C source per transfer, back to back while the queue has
// room, and gives up to two tokens per byte; tokens leave at one per cycle while
// the receiver is ready; the 4-entry queue absorbs bytes that yield two tokens.
// A token passes through the queue and the output register after the byte that
// completes it is taken. The input stalls when under two queue entries are free.
`default_nettype none
module c_token_scanner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cts_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cts_pkg::out_item_t      out_data
);

  cts_pkg::push_t push;
  cts_pkg::rec_t  head;
  logic           room, not_empty, pop;

  cts_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_room(room), .push
  );

  cts_queue u_queue (
    .clk, .rst_n, .push, .room, .pop, .not_empty, .head
  );

  cts_back u_back (
    .clk, .rst_n, .not_empty, .head, .pop, .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for c_token_scanner: drives C source bytes, predicts the tokens.
// Depends on cts_pkg and the scanner RTL; nothing else.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYWORD_LEN = 8;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cts_pkg::out_item_t out_data;

  always #2 clk = ~clk;

  c_token_scanner dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // scanner state for prediction
  cts_pkg::mode_t sc_mode;
  logic [7:0]   sc_word [KEYWORD_LEN];
  logic         sc_long;
  logic [7:0]   sc_pend;
  logic [1:0]   sc_dots;
  logic [31:0]  sc_start;
  logic [15:0]  sc_len;
  logic [15:0]  sc_line;
  logic [31:0]  sc_offset;

  cts_pkg::out_item_t expected_tokens [$];
  cts_pkg::out_item_t step_tokens [$];
  int failures = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  string kw_names [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof",
    "static", "struct", "switch", "typedef", "union", "unsigned", "void",
    "volatile", "while"};

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [6:0] lone_op_code(logic [7:0] b);
    case (b)
      "-": return 7'd33; "!": return 7'd37; "%": return 7'd39; "&": return 7'd41;
      "(": return 7'd44; ")": return 7'd45; "*": return 7'd46; ",": return 7'd48;
      "/": return 7'd50; ":": return 7'd52; ";": return 7'd53; "?": return 7'd54;
      "[": return 7'd55; "]": return 7'd56; "^": return 7'd57; "{": return 7'd59;
      "|": return 7'd60; "}": return 7'd63; "~": return 7'd64; "+": return 7'd65;
      "<": return 7'd68; "=": return 7'd72; ">": return 7'd74; 8'h22: return 7'd78;
      8'h27: return 7'd79; "#": return 7'd80;
      default: return cts_pkg::CODE_NONE;
    endcase
  endfunction

  function automatic bit op_can_grow(logic [7:0] b);
    return b == "-" || b == "!" || b == "%" || b == "*" || b == "^" ||
           b == "=" || b == "/" || b == "&" || b == "|" || b == "+" ||
           b == "<" || b == ">";
  endfunction

  function automatic logic [6:0] two_op_code(logic [7:0] f, logic [7:0] s);
    if (s == "=") begin
      case (f)
        "-": return 7'd35; "!": return 7'd38; "%": return 7'd40; "&": return 7'd43;
        "*": return 7'd47; "/": return 7'd51; "^": return 7'd58; "|": return 7'd62;
        "+": return 7'd67; "<": return 7'd71; "=": return 7'd73; ">": return 7'd75;
        default: return cts_pkg::CODE_NONE;
      endcase
    end
    if (f == "-" && s == "-") return 7'd34;
    if (f == "-" && s == ">") return 7'd36;
    if (f == "&" && s == "&") return 7'd42;
    if (f == "|" && s == "|") return 7'd61;
    if (f == "+" && s == "+") return 7'd66;
    return cts_pkg::CODE_NONE;
  endfunction

  function automatic logic [6:0] word_class();
    int n;
    bit same;
    if (sc_long || sc_len > KEYWORD_LEN) return cts_pkg::CODE_IDENT;
    for (int k = 0; k < 32; k++) begin
      n = kw_names[k].len();
      if (n != sc_len) continue;
      same = 1'b1;
      for (int i = 0; i < n; i++)
        if (sc_word[i] != kw_names[k][i]) same = 1'b0;
      if (same) return 7'(k + 1);
    end
    return cts_pkg::CODE_IDENT;
  endfunction

  task automatic add_token(logic [6:0] code, logic [1:0] err, logic [31:0] start,
                           logic [15:0] len);
    cts_pkg::out_item_t t;
    if (step_tokens.size() >= 2) return;
    t.token_code = code;
    t.error_kind = err;
    t.token_start = start;
    t.token_length = len;
    t.line_number = sc_line;
    t.last_of_run = 1'b0;
    step_tokens = {step_tokens, t};
  endtask

  task automatic close_token();
    logic [6:0] code;
    logic [1:0] err;
    err = cts_pkg::ERR_NONE;
    case (sc_mode)
      cts_pkg::M_IDENT: code = word_class();
      cts_pkg::M_OCT:   code = cts_pkg::CODE_OCT;
      cts_pkg::M_HEX:   code = cts_pkg::CODE_HEX;
      cts_pkg::M_DEC:   code = cts_pkg::CODE_DEC;
      cts_pkg::M_OP:    code = lone_op_code(sc_pend);
      cts_pkg::M_SHIFT: code = (sc_pend == "<") ? cts_pkg::CODE_SHL : cts_pkg::CODE_SHR;
      cts_pkg::M_ESC:   code = cts_pkg::CODE_NONE;
      default: return;
    endcase
    if ((sc_mode == cts_pkg::M_OCT || sc_mode == cts_pkg::M_HEX ||
         sc_mode == cts_pkg::M_DEC) && sc_dots >= 2'd2) begin
      code = cts_pkg::CODE_NONE;
      err = cts_pkg::ERR_DOTS;
    end
    add_token(code, err, sc_start, sc_len);
    sc_mode = cts_pkg::M_IDLE;
  endtask

  task automatic open_token(cts_pkg::mode_t m);
    sc_mode = m;
    sc_start = sc_offset;
    sc_len = 16'd1;
    sc_dots = 2'd0;
  endtask

  task automatic grow(logic [7:0] b);
    if (sc_len != 16'hFFFF) sc_len++;
    if (b == "." && sc_dots < 2'd2) sc_dots++;
  endtask

  task automatic start_token(logic [7:0] b);
    if (letter(b)) begin
      open_token(cts_pkg::M_IDENT);
      sc_word[0] = b;
      sc_long = 1'b0;
    end else if (b == "0") begin
      open_token(cts_pkg::M_OCT);
    end else if (digit(b) || b == ".") begin
      open_token(cts_pkg::M_DEC);
      if (b == ".") sc_dots = 2'd1;
    end else if (b == " " || b == 8'h09 || b == 8'h0D) begin
    end else if (b == 8'h0A) begin
      if (sc_line != 16'hFFFF) sc_line++;
    end else if (b == 8'h5C) begin
      open_token(cts_pkg::M_ESC);
    end else if (op_can_grow(b)) begin
      open_token(cts_pkg::M_OP);
      sc_pend = b;
    end else if (lone_op_code(b) != cts_pkg::CODE_NONE) begin
      add_token(lone_op_code(b), cts_pkg::ERR_NONE, sc_offset, 16'd1);
    end else begin
      add_token(cts_pkg::CODE_NONE, cts_pkg::ERR_UNDEF, sc_offset, 16'd1);
    end
  endtask

  task automatic scan_byte(logic [7:0] b);
    logic [6:0] c;
    case (sc_mode)
      cts_pkg::M_IDENT: if (letter(b) || digit(b)) begin
        if (sc_len < KEYWORD_LEN) sc_word[sc_len[2:0]] = b;
        else sc_long = 1'b1;
        grow(b);
        return;
      end
      cts_pkg::M_OCT: begin
        if (sc_len == 16'd1 && sc_dots == 2'd0 && (b == "x" || b == "X")) begin
          sc_mode = cts_pkg::M_HEX;
          sc_len = 16'd2;
          return;
        end
        if ((b >= "0" && b <= "7") || b == ".") begin
          grow(b);
          return;
        end
      end
      cts_pkg::M_HEX: if (digit(b) || (b >= "A" && b <= "F") || b == ".") begin
        grow(b);
        return;
      end
      cts_pkg::M_DEC: if (digit(b) || b == ".") begin
        grow(b);
        return;
      end
      cts_pkg::M_OP: begin
        if ((sc_pend == "<" || sc_pend == ">") && b == sc_pend) begin
          sc_mode = cts_pkg::M_SHIFT;
          sc_len = 16'd2;
          return;
        end
        c = two_op_code(sc_pend, b);
        if (c != cts_pkg::CODE_NONE) begin
          add_token(c, cts_pkg::ERR_NONE, sc_start, 16'd2);
          sc_mode = cts_pkg::M_IDLE;
          return;
        end
      end
      cts_pkg::M_SHIFT: if (b == "=") begin
        add_token((sc_pend == "<") ? cts_pkg::CODE_SHLEQ : cts_pkg::CODE_SHREQ,
                  cts_pkg::ERR_NONE, sc_start, 16'd3);
        sc_mode = cts_pkg::M_IDLE;
        return;
      end
      cts_pkg::M_ESC: begin
        add_token(cts_pkg::CODE_NONE, cts_pkg::ERR_NONE, sc_start, 16'd2);
        sc_mode = cts_pkg::M_IDLE;
        return;
      end
      default: begin
        start_token(b);
        return;
      end
    endcase
    close_token();
    start_token(b);
  endtask

  task automatic predict_tokens(cts_pkg::in_item_t it);
    step_tokens.delete();
    scan_byte(it.text_byte);
    if (it.end_of_text && sc_mode != cts_pkg::M_IDLE) close_token();
    sc_offset++;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  // directed rows: fixed expectation only where it is obvious
  typedef struct {
    logic [7:0] b;
    logic       eot;
    bit         fixed;
    cts_pkg::out_item_t tok;
  } row_t;

  row_t rows [$];

  task automatic add_row(logic [7:0] b, logic eot, bit fixed = 1'b0,
                         logic [6:0] code = '0, logic [1:0] err = '0,
                         logic [31:0] start = '0, logic [15:0] len = '0);
    row_t r;
    r.b = b;
    r.eot = eot;
    r.fixed = fixed;
    r.tok = '{code, err, start, len, 16'd1, 1'b1};
    rows = {rows, r};
  endtask

  task automatic send_byte(logic [7:0] b, logic eot);
    cts_pkg::in_item_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    predict_tokens(it);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s, bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    string alphabet = "abcxyzAFXx_019785.+-<>=&|!%*/^~(){};,?:#\\\"' \t\r\n";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      default: return alphabet[$urandom_range(alphabet.len() - 1)];
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    string frags [14] = '{"<<=", ">>=", "->", "++", "0x1F", "017", "09", "1.2.3",
                          "..", "while", "unsigned", "identifier_long", "\\\n", "x=y;"};
    string s;
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(2) == 0) begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          send_byte(pick_byte(), $urandom_range(40) == 0);
          sent++;
        end
      end else begin
        s = frags[$urandom_range(13)];
        send_text(s, 1'b0);
        send_byte(pick_byte(), $urandom_range(20) == 0);
        sent += s.len() + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cts_pkg::out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token", 32'(out_data.token_code), 32'd0);
      end else begin
        w = expected_tokens.pop_front();
        if (out_data.token_code !== w.token_code)
          report_mismatch("token_code", 32'(out_data.token_code), 32'(w.token_code));
        if (out_data.error_kind !== w.error_kind)
          report_mismatch("error_kind", 32'(out_data.error_kind), 32'(w.error_kind));
        if (out_data.token_start !== w.token_start)
          report_mismatch("token_start", out_data.token_start, w.token_start);
        if (out_data.token_length !== w.token_length)
          report_mismatch("token_length", 32'(out_data.token_length),
                          32'(w.token_length));
        if (out_data.line_number !== w.line_number)
          report_mismatch("line_number", 32'(out_data.line_number), 32'(w.line_number));
        if (out_data.last_of_run !== w.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run), 32'(w.last_of_run));
      end
    end
  end

  initial begin
    int waited;
    sc_mode = cts_pkg::M_IDLE;
    foreach (sc_word[i]) sc_word[i] = '0;
    sc_long = 1'b0;
    sc_pend = '0;
    sc_dots = '0;
    sc_start = '0;
    sc_len = '0;
    sc_line = 16'd1;
    sc_offset = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(8'h00, 1'b0, 1'b1, cts_pkg::CODE_NONE, cts_pkg::ERR_UNDEF, 32'd0, 16'd1);
    add_row(8'hFF, 1'b0, 1'b1, cts_pkg::CODE_NONE, cts_pkg::ERR_UNDEF, 32'd1, 16'd1);
    add_row("#", 1'b0, 1'b1, 7'd80, cts_pkg::ERR_NONE, 32'd2, 16'd1);
    add_row(".", 1'b1, 1'b1, cts_pkg::CODE_DEC, cts_pkg::ERR_NONE, 32'd3, 16'd1);
    add_row("0", 1'b1, 1'b1, cts_pkg::CODE_OCT, cts_pkg::ERR_NONE, 32'd4, 16'd1);
    add_row(8'h5C, 1'b1, 1'b1, cts_pkg::CODE_NONE, cts_pkg::ERR_NONE, 32'd5, 16'd1);
    add_row("<", 1'b0);
    add_row("<", 1'b0);
    add_row("=", 1'b0);
    add_row("0", 1'b0);
    add_row("x", 1'b0);
    add_row("F", 1'b0);
    add_row(".", 1'b0);
    add_row(".", 1'b0);
    add_row(">", 1'b0);
    add_row(">", 1'b1);
    add_row(8'h5C, 1'b0);
    add_row(8'h0A, 1'b0);
    add_row("i", 1'b0);
    add_row("f", 1'b0);
    add_row("0", 1'b0);
    add_row("8", 1'b0);
    add_row(8'h0A, 1'b0);
    add_row("a", 1'b1);
    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        send_byte(rows[i].b, rows[i].eot);
        expected_tokens[expected_tokens.size() - 1] = rows[i].tok;
      end else send_byte(rows[i].b, rows[i].eot);
    end
    drain();

    foreach (kw_names[k]) send_text({kw_names[k], " "}, 1'b0);
    send_text("volatilex longidentifier 0X 777.1", 1'b1);
    drain();

    random_phase(400, 0, 0);
    random_phase(300, 87, 0);
    random_phase(300, 0, 87);
    random_phase(300, 14, 14);
    hold_off <= 300;
    random_phase(100, 0, 0);
    drain();
    random_phase(200, 50, 50);
    in_valid <= 1'b0;

    waited = 0;
    while (expected_tokens.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hdl/cts_pkg.sv
hdl/cts_front.sv
hdl/cts_queue.sv
hdl/cts_back.sv
hdl/c_token_scanner.sv
tb/sv/tb.sv
